// File: hdl/fdap_pkg.sv
// Package for the fractional-delay allpass: default sizes, register codes,
// fixed gain format and the sequencer state type. No dependencies.
`default_nettype none

package fdap_pkg;

	// Default sizes, handed to the top-level parameters
	localparam int BUFFER_DEPTH_DEF = 1024;
	localparam int SAMPLE_WIDTH_DEF = 16;
	localparam int FRAC_BITS_DEF    = 8;

	// Configuration port
	localparam int CFG_DATA_W  = 18;
	localparam int REG_INDEX_W = 1;
	localparam logic [REG_INDEX_W-1:0] REG_DELAY = 1'b0;
	localparam logic [REG_INDEX_W-1:0] REG_GAIN  = 1'b1;

	// Register widths
	localparam int DELAY_W = 18;
	localparam int GAIN_W  = 16;

	// Gain is Q1.15, limited to +-0.99
	localparam int GAIN_SHIFT = 15;
	localparam logic signed [GAIN_W-1:0] GAIN_LIMIT_POS = 16'sd32440;
	localparam logic signed [GAIN_W-1:0] GAIN_LIMIT_NEG = -16'sd32440;
	localparam logic signed [GAIN_W-1:0] GAIN_RESET     = 16'sd16384;

	// Per-sample sequencer
	typedef enum logic [2:0] {
		S_IDLE,
		S_RD1,
		S_INTERP,
		S_MUL1,
		S_FEED,
		S_MUL2,
		S_OUT
	} fdap_state_t;

endpackage : fdap_pkg

`default_nettype wire

// File: hdl/fdap_in_if.sv
// Input sample channel: valid/ready handshake with one signed sample.
// Depends on fdap_pkg for the default sample width.
`default_nettype none

interface fdap_in_if #(
	parameter int SAMPLE_WIDTH = fdap_pkg::SAMPLE_WIDTH_DEF
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink   (input valid, input sample_in, output ready);
endinterface : fdap_in_if

`default_nettype wire

// File: hdl/fdap_out_if.sv
// Output sample channel: valid/ready handshake with one signed sample.
// Depends on fdap_pkg for the default sample width.
`default_nettype none

interface fdap_out_if #(
	parameter int SAMPLE_WIDTH = fdap_pkg::SAMPLE_WIDTH_DEF
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample_out;

	modport source (output valid, output sample_out, input ready);
	modport sink   (input valid, input sample_out, output ready);
endinterface : fdap_out_if

`default_nettype wire

// File: hdl/fdap_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module fdap_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule : fdap_ram

`default_nettype wire

// File: hdl/fractional_delay_allpass.sv
// Fractional-delay Schroeder allpass. A sample is taken only in S_IDLE, once the last
// is through the sequencer: two reads of the single-read-port history RAM, then two
// dependent gain multiplies; S_OUT waits while the output register is full.
// A sample is accepted while an earlier result still waits in the output register.
// Reset (arst_n) clears write pointer, delay and control, gain = 0.5; history entries
// not yet written since reset read as zero (pointer plus wrap flag), no clearing pass.
`default_nettype none

module fractional_delay_allpass #(
	parameter int BUFFER_DEPTH = fdap_pkg::BUFFER_DEPTH_DEF,
	parameter int SAMPLE_WIDTH = fdap_pkg::SAMPLE_WIDTH_DEF,
	parameter int FRAC_BITS    = fdap_pkg::FRAC_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	fdap_in_if.sink                                  audio,
	fdap_out_if.source                               filtered,
	input  wire logic                                cfg_we,
	input  wire logic [fdap_pkg::REG_INDEX_W-1:0]    cfg_index,
	input  wire logic [fdap_pkg::CFG_DATA_W-1:0]     cfg_data
);

	import fdap_pkg::*;

	localparam int SW = SAMPLE_WIDTH;
	localparam int F  = FRAC_BITS;
	localparam int AW = $clog2(BUFFER_DEPTH);
	localparam int PW = AW + F + 2;
	localparam int PRODW = SW + GAIN_W;

	localparam logic [63:0]   DELAY_MAX = 64'(BUFFER_DEPTH - 1) << F;
	localparam logic [PW-1:0] SPAN      = PW'(BUFFER_DEPTH) << F;
	localparam logic [AW-1:0] LAST_IDX  = AW'(BUFFER_DEPTH - 1);

	// State and registers
	fdap_state_t state_q, state_d;

	logic [DELAY_W-1:0]       delay_q;
	logic signed [GAIN_W-1:0] gain_q;
	logic [AW-1:0]            wp_q;
	logic                     wrapped_q;

	logic signed [SW-1:0]     x_q;
	logic [AW-1:0]            i0_q, i1_q;
	logic [F-1:0]             frac_q;
	logic signed [SW-1:0]     e0_q;
	logic signed [SW-1:0]     delayed_q;
	logic signed [PRODW-1:0]  p1_q, p2_q;
	logic signed [SW-1:0]     ff_q;
	logic                     out_valid_q;
	logic signed [SW-1:0]     out_data_q;

	// Sequencer controls
	logic          accept;
	logic          mem_we;
	logic          out_load;
	logic [AW-1:0] ram_raddr;
	logic [SW-1:0] ram_rdata;

	// Configuration writes with clamping
	logic [63:0]              delay_cand;
	logic signed [GAIN_W-1:0] gain_cand;

	assign delay_cand = 64'(cfg_data);
	assign gain_cand  = $signed(cfg_data[GAIN_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= '0;
			gain_q  <= GAIN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DELAY: begin
					if (delay_cand > DELAY_MAX) begin
						delay_q <= DELAY_MAX[DELAY_W-1:0];
					end else begin
						delay_q <= cfg_data[DELAY_W-1:0];
					end
				end
				REG_GAIN: begin
					if (gain_cand > GAIN_LIMIT_POS) begin
						gain_q <= GAIN_LIMIT_POS;
					end else if (gain_cand < GAIN_LIMIT_NEG) begin
						gain_q <= GAIN_LIMIT_NEG;
					end else begin
						gain_q <= gain_cand;
					end
				end
			endcase
		end
	end

	// Read position: write pointer minus delay minus one, wrapped once
	logic [63:0]   delay_w;
	logic [PW-1:0] base_pos, pos_raw, pos;
	logic [AW-1:0] rd_i0, rd_i1;

	assign delay_w  = 64'(delay_q);
	assign base_pos = (PW'(wp_q) + PW'(BUFFER_DEPTH - 1)) << F;
	assign pos_raw  = base_pos - delay_w[PW-1:0];
	assign pos      = (pos_raw >= SPAN) ? (pos_raw - SPAN) : pos_raw;
	assign rd_i0    = pos[F +: AW];
	assign rd_i1    = (rd_i0 == LAST_IDX) ? AW'(0) : (rd_i0 + AW'(1));

	// History memory
	fdap_ram #(
		.WIDTH (SW),
		.DEPTH (BUFFER_DEPTH)
	) u_hist (
		.clk   (clk),
		.we    (mem_we),
		.waddr (wp_q),
		.wdata (ff_q),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Entries never written since reset read as zero
	logic valid0, valid1;
	logic signed [SW-1:0] e0_rd, e1_rd;

	assign valid0 = wrapped_q || (i0_q < wp_q);
	assign valid1 = wrapped_q || (i1_q < wp_q);
	assign e0_rd  = valid0 ? $signed(ram_rdata) : '0;
	assign e1_rd  = valid1 ? $signed(ram_rdata) : '0;

	// Next-state logic
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:   if (audio.valid) state_d = S_RD1;
			S_RD1:    state_d = S_INTERP;
			S_INTERP: state_d = S_MUL1;
			S_MUL1:   state_d = S_FEED;
			S_FEED:   state_d = S_MUL2;
			S_MUL2:   state_d = S_OUT;
			S_OUT:    if (!out_valid_q || filtered.ready) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// Sequencer outputs; the feedforward value is stored once ff_q holds it
	always_comb begin
		audio.ready = 1'b0;
		mem_we      = 1'b0;
		out_load    = 1'b0;
		ram_raddr   = rd_i0;
		unique case (state_q)
			S_IDLE:   audio.ready = 1'b1;
			S_RD1:    ram_raddr = i1_q;
			S_INTERP: ram_raddr = i1_q;
			S_MUL1:   ;
			S_FEED:   ;
			S_MUL2:   mem_we = 1'b1;
			S_OUT:    out_load = !out_valid_q || filtered.ready;
			default:  ;
		endcase
	end

	assign accept = audio.valid && audio.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Capture sample and read taps on the input transaction
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q    <= audio.sample_in;
			i0_q   <= rd_i0;
			i1_q   <= rd_i1;
			frac_q <= pos[F-1:0];
		end
	end

	// First tap arrives from the RAM
	always_ff @(posedge clk) begin
		if (state_q == S_RD1) begin
			e0_q <= e0_rd;
		end
	end

	// Linear interpolation: e0 + (e1 - e0) * frac, floored
	logic signed [SW:0]      tap_diff;
	logic signed [SW+F+1:0]  tap_prod, tap_base, tap_sum;

	assign tap_diff = $signed({e1_rd[SW-1], e1_rd}) - $signed({e0_q[SW-1], e0_q});
	assign tap_prod = tap_diff * $signed({1'b0, frac_q});
	assign tap_base = $signed({{2{e0_q[SW-1]}}, e0_q, {F{1'b0}}});
	assign tap_sum  = tap_base + tap_prod;

	always_ff @(posedge clk) begin
		if (state_q == S_INTERP) begin
			delayed_q <= tap_sum[SW+F-1:F];
		end
	end

	// Feedback product
	always_ff @(posedge clk) begin
		if (state_q == S_MUL1) begin
			p1_q <= delayed_q * gain_q;
		end
	end

	// Feedforward sum, saturated
	logic signed [SW:0]   fb_term;
	logic signed [SW+1:0] ff_sum;
	logic signed [SW-1:0] ff_sat;

	assign fb_term = p1_q[SW+GAIN_SHIFT:GAIN_SHIFT];
	assign ff_sum  = $signed({{2{x_q[SW-1]}}, x_q}) + $signed({fb_term[SW], fb_term});

	always_comb begin
		if ((ff_sum[SW+1:SW-1] == 3'b000) || (ff_sum[SW+1:SW-1] == 3'b111)) begin
			ff_sat = ff_sum[SW-1:0];
		end else if (ff_sum[SW+1]) begin
			ff_sat = $signed({1'b1, {(SW-1){1'b0}}});
		end else begin
			ff_sat = $signed({1'b0, {(SW-1){1'b1}}});
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FEED) begin
			ff_q <= ff_sat;
		end
	end

	// Write pointer advances when the feedforward value is stored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q      <= '0;
			wrapped_q <= 1'b0;
		end else if (mem_we) begin
			if (wp_q == LAST_IDX) begin
				wp_q      <= '0;
				wrapped_q <= 1'b1;
			end else begin
				wp_q <= wp_q + AW'(1);
			end
		end
	end

	// Feedforward product
	always_ff @(posedge clk) begin
		if (state_q == S_MUL2) begin
			p2_q <= ff_q * gain_q;
		end
	end

	// Output: delayed minus feedforward product, saturated
	logic signed [SW:0]   fw_term;
	logic signed [SW+1:0] y_sum;
	logic signed [SW-1:0] y_sat;

	assign fw_term = p2_q[SW+GAIN_SHIFT:GAIN_SHIFT];
	assign y_sum   = $signed({{2{delayed_q[SW-1]}}, delayed_q})
		- $signed({fw_term[SW], fw_term});

	always_comb begin
		if ((y_sum[SW+1:SW-1] == 3'b000) || (y_sum[SW+1:SW-1] == 3'b111)) begin
			y_sat = y_sum[SW-1:0];
		end else if (y_sum[SW+1]) begin
			y_sat = $signed({1'b1, {(SW-1){1'b0}}});
		end else begin
			y_sat = $signed({1'b0, {(SW-1){1'b1}}});
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (filtered.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= y_sat;
		end
	end

	assign filtered.valid      = out_valid_q;
	assign filtered.sample_out = out_data_q;

	// Assertions
	a_write_after_feed: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == S_MUL2))
		else $error("history write outside the step after the feedforward sum");

	a_pointer_advance: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |=> (wp_q == (($past(wp_q) == LAST_IDX) ? AW'(0) : ($past(wp_q) + AW'(1)))))
		else $error("write pointer did not advance after history write");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && out_valid_q && !filtered.ready) |=> (state_q == S_OUT))
		else $error("result left the sequencer while output register was full");

	a_taps_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD1) |-> ((i0_q <= LAST_IDX) && (i1_q <= LAST_IDX)))
		else $error("interpolation tap beyond buffer depth");

	a_gain_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		(gain_q <= GAIN_LIMIT_POS) && (gain_q >= GAIN_LIMIT_NEG))
		else $error("gain register outside its limits");

	a_delay_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		(64'(delay_q) <= DELAY_MAX))
		else $error("delay register beyond buffer depth");

endmodule : fractional_delay_allpass

`default_nettype wire
